// ----- hdl/vema_pkg.sv -----
// Package for the vector EMA decimator: constants, payload structs,
// CSR index codes and the lane control struct. No dependencies.
package vema_pkg;

   // Fixed payload geometry
   localparam int CHANNELS    = 6;
   localparam int SAMPLE_BITS = 32;

   // CSR widths and reset values
   localparam int ALPHA_BITS     = 17;
   localparam int INTERVAL_BITS  = 16;
   localparam int USED_BITS      = 3;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 17;

   localparam logic [ALPHA_BITS-1:0]    ALPHA_ONE      = 17'd65536;
   localparam logic [ALPHA_BITS-1:0]    ALPHA_RESET    = 17'd13107;
   localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = 16'd1;
   localparam logic [USED_BITS-1:0]     USED_RESET     = 3'd3;

   // Register index codes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ALPHA    = 2'd0,
      CSR_INTERVAL = 2'd1,
      CSR_USED     = 2'd2
   } csr_index_type;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      sample_type value_0;
      sample_type value_1;
      sample_type value_2;
      sample_type value_3;
      sample_type value_4;
      sample_type value_5;
   } req_type;

   typedef struct packed {
      sample_type smoothed_0;
      sample_type smoothed_1;
      sample_type smoothed_2;
      sample_type smoothed_3;
      sample_type smoothed_4;
      sample_type smoothed_5;
   } rsp_type;

   // Control shared by every lane for one transaction
   typedef struct packed {
      logic                  step;   // a sample is accepted this cycle
      logic                  load;   // first sample of a window
      logic [ALPHA_BITS-1:0] alpha;  // clamped to one
      logic [USED_BITS-1:0]  used;   // clamped to CHANNELS
   } lane_ctl_type;

endpackage

// ----- hdl/vema_lane.sv -----
// One smoothing lane: the stored value of one channel and its EMA update.
// Depends on vema_pkg.
module vema_lane #(
   parameter int LANE_INDEX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  vema_pkg::lane_ctl_type ctl,
   input  vema_pkg::sample_type   sample,
   output vema_pkg::sample_type   smoothed_in,
   output vema_pkg::sample_type   smoothed_ff
);

   localparam int SB = vema_pkg::SAMPLE_BITS;
   localparam int PB = SB + 1 + vema_pkg::ALPHA_BITS + 1;

   logic                active;
   logic signed [SB:0]   diff;
   logic signed [vema_pkg::ALPHA_BITS:0] alpha_s;
   logic signed [PB-1:0] prod;
   logic signed [PB-1:0] prod_rnd;
   logic signed [PB-17:0] delta;
   logic signed [PB-17:0] sum;
   vema_pkg::sample_type  update;

   assign active = (4'(LANE_INDEX) < {1'b0, ctl.used});

   // old + round(alpha * (new - old) / 2^16), ties toward plus infinity
   always_comb begin
      diff     = {sample[SB-1], sample} - {smoothed_ff[SB-1], smoothed_ff};
      alpha_s  = {1'b0, ctl.alpha};
      prod     = diff * alpha_s;
      prod_rnd = prod + PB'(32768);
      delta    = prod_rnd[PB-1:16];
      sum      = {{(PB-16-SB){smoothed_ff[SB-1]}}, smoothed_ff} + delta;
      update   = sum[SB-1:0];
   end

   // Next stored value
   always_comb begin
      smoothed_in = smoothed_ff;
      if (ctl.step) begin
         if (!active) begin
            smoothed_in = '0;
         end else if (ctl.load) begin
            smoothed_in = sample;
         end else begin
            smoothed_in = update;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smoothed_ff <= '0;
      end else begin
         smoothed_ff <= smoothed_in;
      end
   end

endmodule

// ----- hdl/vema_out.sv -----
// Output stage: holds the merged result transactions in an output
// register plus a skid entry.
// Depends on vema_pkg.
module vema_out (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  vema_pkg::rsp_type push_data,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output vema_pkg::rsp_type rsp_data,
   output logic              skid_full
);

   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   vema_pkg::rsp_type out_data_ff, out_data_in;
   vema_pkg::rsp_type skid_data_ff, skid_data_in;
   logic              pop;

   assign pop = out_valid_ff && rsp_ready;

   // Two-entry queue; a push only arrives while the skid entry is free
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = push;
            skid_data_in  = push_data;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         if (out_valid_ff) begin
            skid_valid_in = 1'b1;
            skid_data_in  = push_data;
         end else begin
            out_valid_in = 1'b1;
            out_data_in  = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign skid_full = skid_valid_ff;

endmodule

// ----- hdl/vector_ema_decimator.sv -----
// Vector EMA decimator top level: CSRs, window counter, six smoothing
// lanes and the output stage. Depends on vema_pkg, vema_lane, vema_out.
//
// Usage:
//   req_valid/req_ready/req_data carry one six-channel Q16.16 sample per
//   transaction. rsp_valid/rsp_ready/rsp_data carry the smoothed vector,
//   one transaction per window, the window length set by the interval CSR.
//   csr_we/csr_index/csr_wdata write alpha (0), the window interval (1) and
//   channels_in_use (2); write them only while the block is idle.
// Throughput: one sample per cycle while req_ready is high. Each lane has
//   one 33x18 multiplier and its stored value register closes a loop around it.
// Result path: the result of the sample that closes a window is registered
//   in the output register, or in the skid entry behind an earlier result.
// Stall: results queue in an output register and a skid entry; req_ready
//   drops only while both hold a result that the receiver has not taken.
// Reset: synchronous; CSRs return to alpha 0.2, interval 1, three
//   channels; stored values and the window counter clear to zero and the
//   output queue empties.
module vector_ema_decimator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  vema_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output vema_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_we,
   input  logic [vema_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [vema_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int CH = vema_pkg::CHANNELS;

   logic [vema_pkg::ALPHA_BITS-1:0]    alpha_ff;
   logic [vema_pkg::INTERVAL_BITS-1:0] interval_ff;
   logic [vema_pkg::USED_BITS-1:0]     used_ff;
   logic [vema_pkg::INTERVAL_BITS-1:0] count_ff, count_in, count_next;
   logic [vema_pkg::INTERVAL_BITS-1:0] interval_eff;
   logic                               req_accept;
   logic                               emit;
   logic                               push;
   logic                               skid_full;
   vema_pkg::lane_ctl_type             ctl;
   vema_pkg::sample_type [CH-1:0]      lane_sample;
   vema_pkg::sample_type [CH-1:0]      lane_next;
   vema_pkg::sample_type [CH-1:0]      lane_store;
   vema_pkg::rsp_type                  push_data;

   // CSR writes
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff    <= vema_pkg::ALPHA_RESET;
         interval_ff <= vema_pkg::INTERVAL_RESET;
         used_ff     <= vema_pkg::USED_RESET;
      end else if (csr_we) begin
         case (csr_index)
            vema_pkg::CSR_ALPHA:    alpha_ff    <= csr_wdata;
            vema_pkg::CSR_INTERVAL: interval_ff <= csr_wdata[vema_pkg::INTERVAL_BITS-1:0];
            vema_pkg::CSR_USED:     used_ff     <= csr_wdata[vema_pkg::USED_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign req_ready  = !skid_full;
   assign req_accept = req_valid && req_ready;

   // Clamped settings and lane control
   always_comb begin
      ctl.step  = req_accept;
      ctl.load  = (count_ff == '0);
      ctl.alpha = (alpha_ff > vema_pkg::ALPHA_ONE) ? vema_pkg::ALPHA_ONE : alpha_ff;
      ctl.used  = (used_ff > vema_pkg::USED_BITS'(CH)) ? vema_pkg::USED_BITS'(CH) : used_ff;
      interval_eff = (interval_ff == '0) ? vema_pkg::INTERVAL_BITS'(1) : interval_ff;
   end

   // Window counter; the window closes at wrap or once the interval is met
   always_comb begin
      count_next = count_ff + vema_pkg::INTERVAL_BITS'(1);
      emit       = (count_next == '0) || (count_next >= interval_eff);
      count_in   = count_ff;
      if (req_accept) begin
         count_in = emit ? '0 : count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Unpack the sample transaction
   assign lane_sample[0] = req_data.value_0;
   assign lane_sample[1] = req_data.value_1;
   assign lane_sample[2] = req_data.value_2;
   assign lane_sample[3] = req_data.value_3;
   assign lane_sample[4] = req_data.value_4;
   assign lane_sample[5] = req_data.value_5;

   // Smoothing lanes
   for (genvar i = 0; i < CH; i++) begin : g_lane
      vema_lane #(
         .LANE_INDEX (i)
      ) u_lane (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .sample      (lane_sample[i]),
         .smoothed_in (lane_next[i]),
         .smoothed_ff (lane_store[i])
      );
   end

   // Merge lane results into one result transaction
   always_comb begin
      push_data.smoothed_0 = lane_next[0];
      push_data.smoothed_1 = lane_next[1];
      push_data.smoothed_2 = lane_next[2];
      push_data.smoothed_3 = lane_next[3];
      push_data.smoothed_4 = lane_next[4];
      push_data.smoothed_5 = lane_next[5];
   end

   assign push = req_accept && emit;

   vema_out u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .skid_full (skid_full)
   );

`ifndef SYNTH
   // Skid entry only fills behind a held output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_full |-> rsp_valid)
      else $error("skid entry valid without output valid");

   // A result pushed while the output is held lands in the skid entry
   a_push_to_skid: assert property (@(posedge clock) disable iff (reset)
      (push && rsp_valid && !rsp_ready) |=> skid_full)
      else $error("result lost while output stalled");

   // A closed window restarts the counter
   a_window_restart: assert property (@(posedge clock) disable iff (reset)
      push |=> (count_ff == '0))
      else $error("window counter not restarted after result");

   // Each accepted sample clears the stored value of the last lane while it is inactive
   a_inactive_clear: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (ctl.used < vema_pkg::USED_BITS'(CH))) |=> (lane_store[CH-1] == '0))
      else $error("inactive lane kept a value");
`endif

endmodule
